// ===== rtl/s2x_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2x_pkg - Scale2x upscaler shared definitions
// Field widths, register indexes, queue geometry and the job record that
// travels from the window front end to the rule back end.
// ============================================================================
package s2x_pkg;

    localparam int PIX_W         = 32;
    localparam int GEOM_W        = 11;
    localparam int POS_W         = 10;
    localparam int HEIGHT_LIMIT  = 1024;
    localparam int MAX_WIDTH_DEF = 1024;
    localparam int CFG_INDEX_W   = 8;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QUEUE_AW      = $clog2(QUEUE_DEPTH);

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = 8'd1;

    localparam logic [GEOM_W-1:0] GEOM_RESET = 11'd1024;

    typedef logic [PIX_W-1:0] pixel_t;

    typedef struct packed {
        pixel_t             b;
        pixel_t             d;
        pixel_t             e;
        pixel_t             f;
        pixel_t             h;
        logic [POS_W-1:0]   col;
        logic [POS_W-1:0]   row;
        logic               last;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/s2x_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2x_front - raster tracking, line buffer and window
// Takes halo pixels, tracks the halo position, keeps the two previous rows
// in one paired line memory and builds the 3x3 neighborhood jobs.
// ============================================================================
module s2x_front #(
    parameter int MAX_WIDTH = s2x_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [s2x_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [s2x_pkg::GEOM_W-1:0]         cfg_data,
    input  wire logic                               pixel_valid,
    output      logic                               pixel_ready,
    input  wire logic [s2x_pkg::PIX_W-1:0]          pixel,
    input  wire logic                               job_room,
    output      logic                               job_push,
    output      s2x_pkg::job_t                      job
);
    import s2x_pkg::*;

    localparam int LINE_DEPTH = MAX_WIDTH + 2;
    localparam int AW         = $clog2(LINE_DEPTH);

    logic [GEOM_W-1:0]  width_reg;
    logic [GEOM_W-1:0]  height_reg;
    logic [AW-1:0]      col_reg;
    logic [AW-1:0]      col_next;
    logic [GEOM_W-1:0]  row_reg;
    logic [GEOM_W-1:0]  row_next;
    logic [AW-1:0]      eff_w;
    logic [GEOM_W-1:0]  eff_h;

    logic [2*PIX_W-1:0] line_mem [LINE_DEPTH];
    logic [2*PIX_W-1:0] line_rd_reg;

    logic               s1_valid_reg;
    logic               s1_emit_reg;
    logic               s1_last_reg;
    logic [AW-1:0]      s1_addr_reg;
    logic [POS_W-1:0]   s1_col_reg;
    logic [POS_W-1:0]   s1_row_reg;
    pixel_t             s1_pix_reg;

    pixel_t             win_top1_reg;
    pixel_t             win_mid1_reg;
    pixel_t             win_mid2_reg;
    pixel_t             prev_reg;

    pixel_t             rd_top;
    pixel_t             rd_mid;
    logic               s1_fire;
    logic               accept;
    logic               col_wrap;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        if (width_reg == '0)
        begin
            eff_w = AW'(1);
        end
        else if (int'(width_reg) > MAX_WIDTH)
        begin
            eff_w = AW'(MAX_WIDTH);
        end
        else
        begin
            eff_w = AW'(width_reg);
        end

        if (height_reg == '0)
        begin
            eff_h = GEOM_W'(1);
        end
        else if (int'(height_reg) > HEIGHT_LIMIT)
        begin
            eff_h = GEOM_W'(HEIGHT_LIMIT);
        end
        else
        begin
            eff_h = height_reg;
        end
    end

    assign col_wrap = (col_reg == eff_w + AW'(1));

    always_comb
    begin
        if (col_wrap)
        begin
            col_next = '0;
            row_next = (row_reg == eff_h + GEOM_W'(1)) ? '0 : row_reg + GEOM_W'(1);
        end
        else
        begin
            col_next = col_reg + AW'(1);
            row_next = row_reg;
        end
    end

    assign rd_top      = line_rd_reg[2*PIX_W-1:PIX_W];
    assign rd_mid      = line_rd_reg[PIX_W-1:0];
    assign s1_fire     = s1_valid_reg && (!s1_emit_reg || job_room);
    assign pixel_ready = !s1_valid_reg || s1_fire;
    assign accept      = pixel_valid && pixel_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg    <= GEOM_RESET;
            height_reg   <= GEOM_RESET;
            col_reg      <= '0;
            row_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_emit_reg  <= 1'b0;
            s1_last_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    REG_IMAGE_WIDTH:
                    begin
                        width_reg <= cfg_data;
                        col_reg   <= '0;
                        row_reg   <= '0;
                    end
                    REG_IMAGE_HEIGHT:
                    begin
                        height_reg <= cfg_data;
                        col_reg    <= '0;
                        row_reg    <= '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            else if (accept)
            begin
                col_reg <= col_next;
                row_reg <= row_next;
            end

            if (accept)
            begin
                s1_valid_reg <= 1'b1;
                s1_emit_reg  <= (col_reg >= AW'(2)) && (row_reg >= GEOM_W'(2));
                s1_last_reg  <= col_wrap && (row_reg == eff_h + GEOM_W'(1));
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
        end
    end

    // stage payload, line memory and window
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            line_rd_reg <= line_mem[col_reg];
            s1_pix_reg  <= pixel;
            s1_addr_reg <= col_reg;
            s1_col_reg  <= POS_W'(col_reg - AW'(2));
            s1_row_reg  <= POS_W'(row_reg - GEOM_W'(2));
        end
        if (s1_fire)
        begin
            line_mem[s1_addr_reg] <= {rd_mid, s1_pix_reg};
            win_top1_reg          <= rd_top;
            win_mid1_reg          <= rd_mid;
            win_mid2_reg          <= win_mid1_reg;
            prev_reg              <= s1_pix_reg;
        end
    end

    assign job_push = s1_fire && s1_emit_reg;

    always_comb
    begin
        job.b    = win_top1_reg;
        job.d    = win_mid2_reg;
        job.e    = win_mid1_reg;
        job.f    = rd_mid;
        job.h    = prev_reg;
        job.col  = s1_col_reg;
        job.row  = s1_row_reg;
        job.last = s1_last_reg;
    end

endmodule
`default_nettype wire

// ===== rtl/s2x_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2x_queue - job queue
// Short first-in first-out store between the window front end and the rule
// back end so that each side stalls on its own.
// ============================================================================
module s2x_queue (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           push,
    input  wire s2x_pkg::job_t                  din,
    output      logic                           room,
    input  wire logic                           pop,
    output      s2x_pkg::job_t                  dout,
    output      logic                           avail,
    output      logic [s2x_pkg::QUEUE_AW:0]     level
);
    import s2x_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]    wr_ptr_reg;
    logic [QUEUE_AW-1:0]    rd_ptr_reg;
    logic [QUEUE_AW:0]      level_reg;

    assign room  = (level_reg != (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign avail = (level_reg != '0);
    assign dout  = entry_reg[rd_ptr_reg];
    assign level = level_reg;

    function automatic logic [QUEUE_AW-1:0] ptr_inc(input logic [QUEUE_AW-1:0] p);
        logic [QUEUE_AW-1:0] n;
        n = (p == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : p + QUEUE_AW'(1);
        return n;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (push && !pop)
            begin
                level_reg <= level_reg + (QUEUE_AW + 1)'(1);
            end
            else if (pop && !push)
            begin
                level_reg <= level_reg - (QUEUE_AW + 1)'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= din;
        end
    end

endmodule
`default_nettype wire

// ===== rtl/s2x_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// s2x_back - Scale2x rule stage
// Applies the edge equality rules to one neighborhood job and holds the four
// doubled pixels in the output register until taken.
// ============================================================================
module s2x_back (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           job_avail,
    input  wire s2x_pkg::job_t                  job,
    output      logic                           job_pop,
    output      logic                           result_valid,
    input  wire logic                           result_ready,
    output      logic [s2x_pkg::PIX_W-1:0]      out_nw,
    output      logic [s2x_pkg::PIX_W-1:0]      out_ne,
    output      logic [s2x_pkg::PIX_W-1:0]      out_sw,
    output      logic [s2x_pkg::PIX_W-1:0]      out_se,
    output      logic [s2x_pkg::POS_W-1:0]      src_col,
    output      logic [s2x_pkg::POS_W-1:0]      src_row,
    output      logic                           frame_end
);
    import s2x_pkg::*;

    logic               valid_reg;
    pixel_t             nw_reg;
    pixel_t             ne_reg;
    pixel_t             sw_reg;
    pixel_t             se_reg;
    logic [POS_W-1:0]   col_reg;
    logic [POS_W-1:0]   row_reg;
    logic               last_reg;

    logic               open;
    pixel_t             nw_next;
    pixel_t             ne_next;
    pixel_t             sw_next;
    pixel_t             se_next;

    assign job_pop = job_avail && (!valid_reg || result_ready);

    always_comb
    begin
        open    = (job.b != job.h) && (job.d != job.f);
        nw_next = (open && job.d == job.b) ? job.d : job.e;
        ne_next = (open && job.b == job.f) ? job.f : job.e;
        sw_next = (open && job.d == job.h) ? job.d : job.e;
        se_next = (open && job.h == job.f) ? job.f : job.e;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (job_pop)
        begin
            valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_pop)
        begin
            nw_reg   <= nw_next;
            ne_reg   <= ne_next;
            sw_reg   <= sw_next;
            se_reg   <= se_next;
            col_reg  <= job.col;
            row_reg  <= job.row;
            last_reg <= job.last;
        end
    end

    assign result_valid = valid_reg;
    assign out_nw       = nw_reg;
    assign out_ne       = ne_reg;
    assign out_sw       = sw_reg;
    assign out_se       = se_reg;
    assign src_col      = col_reg;
    assign src_row      = row_reg;
    assign frame_end    = last_reg;

endmodule
`default_nettype wire

// ===== rtl/scale2x_pixel_upscaler.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// scale2x_pixel_upscaler - streaming Scale2x 2x upscaler
// Haloed raster in, four doubled pixels per interior source pixel out.
// ============================================================================
// Feed (image_width+2) x (image_height+2) halo pixels in raster order, edge
// rows and columns repeated. One pixel is taken every clock when the result
// side keeps up. The rate is set by the paired line memory (MAX_WIDTH+2 words
// of 64 bits, one read and one write per cycle), which holds the two previous
// halo rows; its contents are undefined after reset and need no clearing
// pass, as every entry is written in a frame before it is read. Pixels in the
// first two halo rows and columns give no result. Any geometry write restarts
// the frame; write geometry only while no beat is in flight. A width of zero
// acts as one and widths above MAX_WIDTH are clamped, likewise heights to
// 1..1024.
// ============================================================================
module scale2x_pixel_upscaler #(
    parameter int MAX_WIDTH = s2x_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_valid,
    output      logic                               cfg_ready,
    input  wire logic [s2x_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [s2x_pkg::GEOM_W-1:0]         cfg_data,
    input  wire logic                               pixel_valid,
    output      logic                               pixel_ready,
    input  wire logic [s2x_pkg::PIX_W-1:0]          pixel,
    output      logic                               result_valid,
    input  wire logic                               result_ready,
    output      logic [s2x_pkg::PIX_W-1:0]          out_nw,
    output      logic [s2x_pkg::PIX_W-1:0]          out_ne,
    output      logic [s2x_pkg::PIX_W-1:0]          out_sw,
    output      logic [s2x_pkg::PIX_W-1:0]          out_se,
    output      logic [s2x_pkg::POS_W-1:0]          src_col,
    output      logic [s2x_pkg::POS_W-1:0]          src_row,
    output      logic                               frame_end
);
    import s2x_pkg::*;

    job_t               push_job;
    job_t               head_job;
    logic               job_push;
    logic               job_room;
    logic               job_pop;
    logic               job_avail;
    logic [QUEUE_AW:0]  queue_level;

    s2x_front #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .pixel_valid (pixel_valid),
        .pixel_ready (pixel_ready),
        .pixel       (pixel),
        .job_room    (job_room),
        .job_push    (job_push),
        .job         (push_job)
    );

    s2x_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (job_push),
        .din   (push_job),
        .room  (job_room),
        .pop   (job_pop),
        .dout  (head_job),
        .avail (job_avail),
        .level (queue_level)
    );

    s2x_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_avail    (job_avail),
        .job          (head_job),
        .job_pop      (job_pop),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_nw       (out_nw),
        .out_ne       (out_ne),
        .out_sw       (out_sw),
        .out_se       (out_se),
        .src_col      (src_col),
        .src_row      (src_row),
        .frame_end    (frame_end)
    );

    a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
        job_push |-> job_room)
        else $error("job pushed into a full queue");

    a_pop_has_job: assert property (@(posedge clk) disable iff (!rst_n)
        job_pop |-> job_avail)
        else $error("job popped from an empty queue");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        queue_level <= (QUEUE_AW + 1)'(QUEUE_DEPTH))
        else $error("queue level beyond depth");

    a_level_track: assert property (@(posedge clk) disable iff (!rst_n)
        (job_push && !job_pop) |=> queue_level == $past(queue_level) + 1'b1)
        else $error("queue level lost a push");

endmodule
`default_nettype wire

// ===== verif/scale2x_pixel_upscaler_tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// scale2x_pixel_upscaler_tb - self-checking bench for the Scale2x upscaler
// Streams haloed frames through the block under random stalls on both sides.
// A scoreboard keeps its own line buffers and window taps, and predicts each
// doubled-pixel quad. Results are compared field by field in order. Geometry
// is swept over small frames, zero sizes that act as one and long single
// rows, with register writes that restart a frame and writes to unused
// indexes that must not.
// ============================================================================
module scale2x_pixel_upscaler_tb;
    import s2x_pkg::*;

    localparam int          LINE_WORDS    = MAX_WIDTH_DEF + 2;
    localparam int          IDLE_PCT      = 31;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          RANDOM_PIXELS = 320;
    localparam int          MAX_SHOWN     = 40;
    localparam int unsigned NO_STOP       = 32'hFFFF_FFFF;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 8'hFE;

    typedef struct {
        pixel_t           nw;
        pixel_t           ne;
        pixel_t           sw;
        pixel_t           se;
        logic [POS_W-1:0] col;
        logic [POS_W-1:0] row;
        logic             last;
    } quad_t;

    class quad_scoreboard;
        logic [GEOM_W-1:0] width_reg;
        logic [GEOM_W-1:0] height_reg;
        pixel_t            line_two_up[LINE_WORDS];
        pixel_t            line_one_up[LINE_WORDS];
        pixel_t            last_pixel;
        pixel_t            up_tap;
        pixel_t            centre_tap;
        pixel_t            left_tap;
        int unsigned       col_pos;
        int unsigned       row_pos;
        quad_t             expected_q[$];
        int unsigned       errors;
        int unsigned       checked;

        function new();
            width_reg  = GEOM_RESET;
            height_reg = GEOM_RESET;
            foreach (line_two_up[i]) begin
                line_two_up[i] = '0;
                line_one_up[i] = '0;
            end
            last_pixel = '0;
            up_tap     = '0;
            centre_tap = '0;
            left_tap   = '0;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function int unsigned frame_w();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
            return width_reg;
        endfunction

        function int unsigned frame_h();
            if (height_reg == 0) return 1;
            if (height_reg > HEIGHT_LIMIT) return HEIGHT_LIMIT;
            return height_reg;
        endfunction

        function void write_reg(logic [CFG_INDEX_W-1:0] idx, logic [GEOM_W-1:0] val);
            if (idx == REG_IMAGE_WIDTH) width_reg = val;
            else if (idx == REG_IMAGE_HEIGHT) height_reg = val;
            else return;
            col_pos = 0;
            row_pos = 0;
        endfunction

        function void take_pixel(pixel_t p);
            int unsigned w;
            int unsigned h;
            pixel_t      top;
            pixel_t      mid;
            bit          rules_on;
            quad_t       q;
            w   = frame_w();
            h   = frame_h();
            top = line_two_up[col_pos];
            mid = line_one_up[col_pos];
            if (col_pos >= 2 && row_pos >= 2) begin
                // above, left, centre, right, below = up_tap, left_tap, centre_tap, mid, last_pixel
                rules_on = (up_tap != last_pixel) && (left_tap != mid);
                q.nw   = (rules_on && left_tap == up_tap) ? left_tap : centre_tap;
                q.ne   = (rules_on && up_tap == mid) ? mid : centre_tap;
                q.sw   = (rules_on && left_tap == last_pixel) ? left_tap : centre_tap;
                q.se   = (rules_on && last_pixel == mid) ? mid : centre_tap;
                q.col  = POS_W'(col_pos - 2);
                q.row  = POS_W'(row_pos - 2);
                q.last = (col_pos == w + 1) && (row_pos == h + 1);
                expected_q.push_back(q);
            end
            left_tap   = centre_tap;
            centre_tap = mid;
            up_tap     = top;
            last_pixel = p;
            line_two_up[col_pos] = mid;
            line_one_up[col_pos] = p;
            col_pos++;
            if (col_pos >= w + 2) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= h + 2) row_pos = 0;
            end
        endfunction

        task report(string what);
            errors++;
            if (errors <= MAX_SHOWN) $display("ERROR at %0t: %s", $time, what);
        endtask

        task check_quad(quad_t got);
            quad_t want;
            if (expected_q.size() == 0) begin
                report($sformatf("result beat with nothing expected (col %0d row %0d)",
                                 got.col, got.row));
                return;
            end
            want = expected_q.pop_front();
            checked++;
            if (got.nw !== want.nw)
                report($sformatf("out_nw %h, want %h", got.nw, want.nw));
            if (got.ne !== want.ne)
                report($sformatf("out_ne %h, want %h", got.ne, want.ne));
            if (got.sw !== want.sw)
                report($sformatf("out_sw %h, want %h", got.sw, want.sw));
            if (got.se !== want.se)
                report($sformatf("out_se %h, want %h", got.se, want.se));
            if (got.col !== want.col)
                report($sformatf("src_col %0d, want %0d", got.col, want.col));
            if (got.row !== want.row)
                report($sformatf("src_row %0d, want %0d", got.row, want.row));
            if (got.last !== want.last)
                report($sformatf("frame_end %b, want %b at col %0d row %0d",
                                 got.last, want.last, want.col, want.row));
        endtask
    endclass

    logic                   clk          = 1'b0;
    logic                   rst_n        = 1'b0;
    logic                   cfg_valid    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index    = '0;
    logic [GEOM_W-1:0]      cfg_data     = '0;
    logic                   pixel_valid  = 1'b0;
    pixel_t                 pixel        = '0;
    logic                   result_ready = 1'b0;
    logic                   cfg_ready;
    logic                   pixel_ready;
    logic                   result_valid;
    pixel_t                 out_nw;
    pixel_t                 out_ne;
    pixel_t                 out_sw;
    pixel_t                 out_se;
    logic [POS_W-1:0]       src_col;
    logic [POS_W-1:0]       src_row;
    logic                   frame_end;

    quad_scoreboard sb;
    bit             calm;
    int unsigned    pixels_sent;
    int unsigned    frames_sent;
    pixel_t         palette[4];
    int unsigned    palette_size;

    scale2x_pixel_upscaler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .out_nw       (out_nw),
        .out_ne       (out_ne),
        .out_sw       (out_sw),
        .out_se       (out_se),
        .src_col      (src_col),
        .src_row      (src_row),
        .frame_end    (frame_end)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && result_ready)
            sb.check_quad('{out_nw, out_ne, out_sw, out_se, src_col, src_row, frame_end});
        result_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end

    function automatic pixel_t pick_colour();
        if ($urandom_range(15) == 0) return $urandom;
        return palette[$urandom_range(palette_size - 1)];
    endfunction

    task automatic send_pixel(input pixel_t p);
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            pixel_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < IDLE_PCT) @(posedge clk);
        end
        pixel_valid <= 1'b1;
        pixel       <= p;
        do @(posedge clk); while (!pixel_ready);
        sb.take_pixel(p);
        pixels_sent++;
    endtask

    task automatic settle();
        pixel_valid <= 1'b0;
        while (sb.expected_q.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [GEOM_W-1:0] val, input bit drop_after);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        if (drop_after) cfg_valid <= 1'b0;
        sb.write_reg(idx, val);
    endtask

    task automatic set_geometry(input logic [GEOM_W-1:0] w, input logic [GEOM_W-1:0] h);
        settle();
        if ($urandom_range(1)) begin
            write_cfg(REG_IMAGE_WIDTH, w, 1'b0);
            write_cfg(REG_IMAGE_HEIGHT, h, 1'b1);
        end
        else begin
            write_cfg(REG_IMAGE_HEIGHT, h, 1'b0);
            write_cfg(REG_IMAGE_WIDTH, w, 1'b1);
        end
    endtask

    // noisy frames ignore the halo rule; stop_at and pause_at count beats in the frame
    task automatic run_frame(input bit noisy, input int unsigned stop_at,
                             input int unsigned pause_at);
        pixel_t      src[$];
        int unsigned w;
        int unsigned h;
        int unsigned n;
        int unsigned sr;
        int unsigned sc;
        w = sb.frame_w();
        h = sb.frame_h();
        palette_size = $urandom_range(2, 4);
        foreach (palette[i]) palette[i] = $urandom;
        if (!noisy)
            for (int i = 0; i < w * h; i++) src.push_back(pick_colour());
        n = 0;
        for (int hr = 0; hr < h + 2; hr++) begin
            for (int hc = 0; hc < w + 2; hc++) begin
                if (n == stop_at) return;
                if (n == pause_at) begin
                    settle();
                    write_cfg(CFG_INDEX_W'($urandom_range(255, REG_IMAGE_HEIGHT + 1)),
                              GEOM_W'($urandom), 1'b1);
                end
                sr = (hr == 0) ? 0 : (hr > h) ? h - 1 : hr - 1;
                sc = (hc == 0) ? 0 : (hc > w) ? w - 1 : hc - 1;
                send_pixel(noisy ? pick_colour() : src[sr * w + sc]);
                n++;
            end
        end
        frames_sent++;
    endtask

    // single-pixel frame: the nine beats form the window directly
    task automatic send_window(input pixel_t above, left, centre, right, below);
        send_pixel($urandom);
        send_pixel(above);
        send_pixel($urandom);
        send_pixel(left);
        send_pixel(centre);
        send_pixel(right);
        send_pixel($urandom);
        send_pixel(below);
        send_pixel($urandom);
        frames_sent++;
    endtask

    initial
    begin
        int unsigned       rand_base;
        int unsigned       phase;
        int unsigned       frame_beats;
        int unsigned       frames;
        logic [GEOM_W-1:0] w;
        logic [GEOM_W-1:0] h;
        sb          = new();
        calm        = 1'b0;
        pixels_sent = 0;
        frames_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        set_geometry(11'd1, 11'd1);
        send_window(32'h0, 32'h0, $urandom, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_window(32'h0, 32'hFFFF_FFFF, $urandom, 32'h0, 32'hFFFF_FFFF);
        send_window(32'h0, 32'h0, $urandom, 32'hFFFF_FFFF, 32'h0);
        settle();
        write_cfg(REG_SPARE, 11'h7FF, 1'b1);
        run_frame(1'b0, NO_STOP, NO_STOP);

        set_geometry(11'd0, 11'd0);
        run_frame(1'b1, NO_STOP, NO_STOP);
        run_frame(1'b0, NO_STOP, NO_STOP);

        rand_base = pixels_sent;
        phase     = 0;
        while (pixels_sent - rand_base < RANDOM_PIXELS) begin
            calm = (phase >= 3 && phase < 7);
            w = ($urandom_range(9) == 0) ? '0 : GEOM_W'($urandom_range(1, 8));
            h = ($urandom_range(9) == 0) ? '0 : GEOM_W'($urandom_range(1, 6));
            if ($urandom_range(11) == 0) begin
                w = GEOM_W'($urandom_range(20, 60));
                h = GEOM_W'(1);
            end
            if ($urandom_range(4) == 0) begin
                settle();
                if ($urandom_range(1)) write_cfg(REG_IMAGE_WIDTH, w, 1'b1);
                else write_cfg(REG_IMAGE_HEIGHT, h, 1'b1);
            end
            else
                set_geometry(w, h);
            frame_beats = (sb.frame_w() + 2) * (sb.frame_h() + 2);
            frames      = $urandom_range(1, 3);
            for (int f = 0; f < frames; f++)
                run_frame($urandom_range(4) == 0,
                          (f == frames - 1 && $urandom_range(5) == 0) ?
                              $urandom_range(1, frame_beats - 1) : NO_STOP,
                          ($urandom_range(7) == 0) ?
                              $urandom_range(1, frame_beats - 1) : NO_STOP);
            phase++;
        end
        calm = 1'b0;
        settle();

        $display("Ran %0d complete frames, %0d pixel beats in, %0d quads checked;",
                 frames_sent, pixels_sent, sb.checked);
        $display("frames from one pixel to sixty columns, zero sizes, random stalls.");
        if (sb.errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("Timeout: %0d quads still expected", sb.expected_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== scale2x_pixel_upscaler.f =====
rtl/s2x_pkg.sv
rtl/s2x_front.sv
rtl/s2x_queue.sv
rtl/s2x_back.sv
rtl/scale2x_pixel_upscaler.sv
verif/scale2x_pixel_upscaler_tb.sv
